// ===== src/kcms_pkg.sv =====
// Shared types, codes and arithmetic helpers for the keyed count merge sort block.
`default_nettype none
package kcms_pkg;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   localparam int SUM_BITS = 32;
   localparam int CNT_BITS = 16;

   typedef struct packed {
      logic                op;
      logic [31:0]         key;
      logic [CNT_BITS-1:0] happen_count;
      logic [CNT_BITS-1:0] present_count;
      logic [CNT_BITS-1:0] inherit_count;
      logic [CNT_BITS-1:0] node_count;
   } req_type;

   typedef struct packed {
      logic [31:0]         key_res;
      logic [SUM_BITS-1:0] happen_sum;
      logic [SUM_BITS-1:0] present_sum;
      logic [SUM_BITS-1:0] inherit_sum;
      logic [SUM_BITS-1:0] node_sum;
      logic                entry_valid;
      logic                dropped;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] happen;
      logic [SUM_BITS-1:0] present;
      logic [SUM_BITS-1:0] inherit;
      logic [SUM_BITS-1:0] node;
   } sums_type;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                    input logic [CNT_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {{(SUM_BITS-CNT_BITS+1){1'b0}}, b};
      return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/kcms_table.sv =====
// Entry table: key and sum memories with one write port and one registered read port.
`default_nettype none
module kcms_table #(
   parameter int DEPTH = 64,
   parameter int KW    = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [KW-1:0]            wr_key,
   input  wire kcms_pkg::sums_type       wr_sums,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [KW-1:0]            rd_key_ff,
   output      kcms_pkg::sums_type       rd_sums_ff
);
   import kcms_pkg::*;

   logic [KW-1:0] key_mem [DEPTH];
   sums_type      sum_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         sum_mem[wr_addr] <= wr_sums;
      end
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_sums_ff <= sum_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== src/keyed_count_merge_sort.sv =====
// Top level: groups records by key, sums their counts and emits them sorted by happen sum.
//
// Usage: an add transaction (op = add) on req_ looks its key up in the entry table,
// one stored entry per cycle; a new key is appended, a stored key gets its four
// counts added with saturation, and a new key with the table full is dropped and
// remembered. An add gives no result. An emit transaction (op = emit) sends every
// entry on rsp_ in descending order of happen sum, equal sums in insertion order,
// then clears the table. Each result costs one full scan of the table, then a read
// of the chosen entry and its write to the output register; an empty table gives
// one result with entry_valid low. req_ready is high only while no transaction is
// in progress. Results go through an output register; a stall on rsp_ready holds
// the sort until the register frees.
// Reset clears the entry count and the drop flag; table contents need no clearing.
`default_nettype none
module keyed_count_merge_sort #(
   parameter int ENTRIES  = 64,
   parameter int KEY_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire kcms_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      kcms_pkg::rsp_type rsp_data
);
   import kcms_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int SK = (KEY_BITS < 32) ? KEY_BITS : 32;

   typedef enum logic [2:0] {
      S_IDLE, S_ADD_SCAN, S_SORT_SCAN, S_SORT_READ, S_SORT_OUT, S_EMPTY
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       cmp_ff, cmp_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [SUM_BITS-1:0] best_v_ff, best_v_in;
   logic [AW-1:0]       best_idx_ff, best_idx_in;
   logic                found_ff, found_in;
   logic [SUM_BITS-1:0] prev_v_ff, prev_v_in;
   logic [AW-1:0]       prev_idx_ff, prev_idx_in;
   logic                first_ff, first_in;
   logic [CW-1:0]       sent_ff, sent_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [SK-1:0] wr_key, rd_key;
   sums_type      wr_sums, rd_sums;
   logic          hit, elig, take, out_free, is_last;

   kcms_table #(.DEPTH(ENTRIES), .KW(SK)) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_key     (wr_key),
      .wr_sums    (wr_sums),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_key_ff  (rd_key),
      .rd_sums_ff (rd_sums)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign hit      = pend_ff && (rd_key == req_ff.key[SK-1:0]);
   assign elig     = first_ff || (rd_sums.happen < prev_v_ff) ||
                     ((rd_sums.happen == prev_v_ff) && (cmp_ff > prev_idx_ff));
   // strict compare keeps the lowest index among equal sums
   assign take     = pend_ff && elig && (!found_ff || (rd_sums.happen > best_v_ff));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_last  = (CW'(sent_ff + 1'b1) == count_ff);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      cmp_in       = cmp_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      best_v_in    = best_v_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      prev_v_in    = prev_v_ff;
      prev_idx_in  = prev_idx_ff;
      first_in     = first_ff;
      sent_in      = sent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = cmp_ff;
      wr_key       = req_ff.key[SK-1:0];
      wr_sums      = '0;
      rd_en        = 1'b0;
      rd_addr      = scan_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               scan_in  = '0;
               pend_in  = 1'b0;
               first_in = 1'b1;
               found_in = 1'b0;
               sent_in  = '0;
               if (req_data.op == OP_ADD)
                  state_in = S_ADD_SCAN;
               else if (count_ff == '0)
                  state_in = S_EMPTY;
               else
                  state_in = S_SORT_SCAN;
            end
         end

         S_ADD_SCAN: begin
            if (hit) begin
               wr_en           = 1'b1;
               wr_addr         = cmp_ff;
               wr_sums.happen  = sat_add(rd_sums.happen, req_ff.happen_count);
               wr_sums.present = sat_add(rd_sums.present, req_ff.present_count);
               wr_sums.inherit = sat_add(rd_sums.inherit, req_ff.inherit_count);
               wr_sums.node    = sat_add(rd_sums.node, req_ff.node_count);
               state_in        = S_IDLE;
            end else if (scan_ff == count_ff) begin
               if (count_ff < CW'(ENTRIES)) begin
                  wr_en           = 1'b1;
                  wr_addr         = count_ff[AW-1:0];
                  wr_sums.happen  = SUM_BITS'(req_ff.happen_count);
                  wr_sums.present = SUM_BITS'(req_ff.present_count);
                  wr_sums.inherit = SUM_BITS'(req_ff.inherit_count);
                  wr_sums.node    = SUM_BITS'(req_ff.node_count);
                  count_in        = CW'(count_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               cmp_in  = scan_ff[AW-1:0];
               scan_in = CW'(scan_ff + 1'b1);
               pend_in = 1'b1;
            end
         end

         S_SORT_SCAN: begin
            if (take) begin
               best_v_in   = rd_sums.happen;
               best_idx_in = cmp_ff;
               found_in    = 1'b1;
            end
            if (scan_ff == count_ff) begin
               pend_in  = 1'b0;
               state_in = S_SORT_READ;
            end else begin
               rd_en   = 1'b1;
               cmp_in  = scan_ff[AW-1:0];
               scan_in = CW'(scan_ff + 1'b1);
               pend_in = 1'b1;
            end
         end

         S_SORT_READ: begin
            rd_en    = 1'b1;
            rd_addr  = best_idx_ff;
            state_in = S_SORT_OUT;
         end

         S_SORT_OUT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.key_res      = 32'(rd_key);
               rsp_in.happen_sum   = rd_sums.happen;
               rsp_in.present_sum  = rd_sums.present;
               rsp_in.inherit_sum  = rd_sums.inherit;
               rsp_in.node_sum     = rd_sums.node;
               rsp_in.entry_valid  = 1'b1;
               rsp_in.dropped      = ovf_ff;
               rsp_in.last         = is_last;
               sent_in             = CW'(sent_ff + 1'b1);
               prev_v_in           = best_v_ff;
               prev_idx_in         = best_idx_ff;
               first_in            = 1'b0;
               found_in            = 1'b0;
               scan_in             = '0;
               pend_in             = 1'b0;
               if (is_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SORT_SCAN;
               end
            end
         end

         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.dropped = ovf_ff;
               rsp_in.last    = 1'b1;
               ovf_in         = 1'b0;
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         found_ff     <= 1'b0;
         first_ff     <= 1'b1;
         sent_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         found_ff     <= found_in;
         first_ff     <= first_in;
         sent_ff      <= sent_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      cmp_ff      <= cmp_in;
      best_v_ff   <= best_v_in;
      best_idx_ff <= best_idx_in;
      prev_v_ff   <= prev_v_in;
      prev_idx_ff <= prev_idx_in;
      rsp_ff      <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== dv/tb_keyed_count_merge_sort.sv =====
// Self-checking testbench for keyed_count_merge_sort: directed table, random runs, scoreboard.
`timescale 1ns / 1ps
module tb_keyed_count_merge_sort;
   import kcms_pkg::*;

   localparam int ENTRIES   = 64;
   localparam int LIMIT     = 3000000;
   localparam int RAND_ITEMS = 330;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   keyed_count_merge_sort #(.ENTRIES(ENTRIES), .KEY_BITS(32)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the group table
   logic [31:0] tbl_key   [ENTRIES];
   sums_type    tbl_sums  [ENTRIES];
   int          tbl_count = 0;
   logic        tbl_dropped = 1'b0;

   rsp_type sorted_q[$];
   int      errors = 0;
   int      cycles = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_cycles = 0;
   int      sent_items = 0;

   typedef struct {
      req_type req;
      bit      literal;
      rsp_type rsp;
   } dir_row_type;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   function automatic logic [31:0] sum_sat(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // apply one transaction to the shadow table, queue the results it causes
   task automatic group_and_sort(input req_type r);
      int      order[ENTRIES];
      int      j, idx;
      rsp_type res;
      bit      hit;
      hit = 0;
      if (r.op == OP_ADD) begin
         for (int i = 0; i < tbl_count; i++) begin
            if (!hit && tbl_key[i] == r.key) begin
               tbl_sums[i].happen  = sum_sat(tbl_sums[i].happen,  r.happen_count);
               tbl_sums[i].present = sum_sat(tbl_sums[i].present, r.present_count);
               tbl_sums[i].inherit = sum_sat(tbl_sums[i].inherit, r.inherit_count);
               tbl_sums[i].node    = sum_sat(tbl_sums[i].node,    r.node_count);
               hit = 1;
            end
         end
         if (!hit) begin
            if (tbl_count >= ENTRIES) begin
               tbl_dropped = 1'b1;
            end else begin
               tbl_key[tbl_count]  = r.key;
               tbl_sums[tbl_count] = {16'd0, r.happen_count, 16'd0, r.present_count,
                                      16'd0, r.inherit_count, 16'd0, r.node_count};
               tbl_count++;
            end
         end
      end else begin
         if (tbl_count == 0) begin
            res = '0;
            res.dropped = tbl_dropped;
            res.last = 1'b1;
            sorted_q.insert(sorted_q.size(), res);
         end
         // stable insertion sort, descending happen sum
         for (int i = 0; i < tbl_count; i++) begin
            idx = i;
            j = i;
            while (j > 0 && tbl_sums[order[j-1]].happen < tbl_sums[idx].happen) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = idx;
         end
         for (int i = 0; i < tbl_count; i++) begin
            res.key_res     = tbl_key[order[i]];
            res.happen_sum  = tbl_sums[order[i]].happen;
            res.present_sum = tbl_sums[order[i]].present;
            res.inherit_sum = tbl_sums[order[i]].inherit;
            res.node_sum    = tbl_sums[order[i]].node;
            res.entry_valid = 1'b1;
            res.dropped     = tbl_dropped;
            res.last        = (i == tbl_count - 1);
            sorted_q.insert(sorted_q.size(), res);
         end
         tbl_count = 0;
         tbl_dropped = 1'b0;
      end
   endtask

   task automatic send(input req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   function automatic req_type make_add(input logic [31:0] k);
      req_type r;
      r.op = OP_ADD;
      r.key = k;
      r.happen_count  = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      r.present_count = 16'($urandom_range(0, 65535));
      r.inherit_count = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
      r.node_count    = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
      return r;
   endfunction

   function automatic req_type make_emit();
      req_type r;
      r = '0;
      r.op = OP_EMIT;
      r.key = $urandom;
      return r;
   endfunction

   task automatic send_checked(input req_type r);
      send(r);
      group_and_sort(r);
   endtask

   // one group run: adds over a small key pool (random keys for a long run), mostly followed by an emit
   task automatic random_run();
      logic [31:0] pool[8];
      int          len;
      for (int i = 0; i < 8; i++) pool[i] = $urandom;
      pool[0] = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
      len = ($urandom_range(0, 24) == 0) ? 70 : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
         if (len > 10) send_checked(make_add($urandom));
         else send_checked(make_add(pool[$urandom_range(0, 7)]));
      end
      if ($urandom_range(0, 5) != 0) send_checked(make_emit());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sorted_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_keyed_count_merge_sort: FAIL");
         $finish;
      end
   end

   // result side: check each transaction, then decide ready for the next cycle
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_q.size() == 0) begin
            report("unexpected result key", rsp_data.key_res, 32'd0);
         end else begin
            want = sorted_q.pop_front();
            if (rsp_data.key_res !== want.key_res)
               report("key_res", rsp_data.key_res, want.key_res);
            if (rsp_data.happen_sum !== want.happen_sum)
               report("happen_sum", rsp_data.happen_sum, want.happen_sum);
            if (rsp_data.present_sum !== want.present_sum)
               report("present_sum", rsp_data.present_sum, want.present_sum);
            if (rsp_data.inherit_sum !== want.inherit_sum)
               report("inherit_sum", rsp_data.inherit_sum, want.inherit_sum);
            if (rsp_data.node_sum !== want.node_sum)
               report("node_sum", rsp_data.node_sum, want.node_sum);
            if (rsp_data.entry_valid !== want.entry_valid)
               report("entry_valid", 32'(rsp_data.entry_valid), 32'(want.entry_valid));
            if (rsp_data.dropped !== want.dropped)
               report("dropped", 32'(rsp_data.dropped), 32'(want.dropped));
            if (rsp_data.last !== want.last)
               report("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   dir_row_type dir_rows[$];

   task automatic add_row(input logic op, input logic [31:0] k, input logic [15:0] h,
                          input logic [15:0] p, input logic [15:0] i, input logic [15:0] n,
                          input bit literal, input rsp_type want);
      dir_row_type row;
      row.req = {op, k, h, p, i, n};
      row.literal = literal;
      row.rsp = want;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   initial begin
      rsp_type empty_rsp;
      int      base;
      empty_rsp = '0;
      empty_rsp.last = 1'b1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty emit after reset, field extremes, ties, repeat keys
      add_row(OP_EMIT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1, empty_rsp);
      add_row(OP_ADD, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0, '0);
      add_row(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0);
      add_row(OP_ADD, 32'd0, 16'd1, 16'd2, 16'd3, 16'd4, 0, '0);
      add_row(OP_ADD, 32'h5555_AAAA, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 0, '0);
      add_row(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0);
      add_row(OP_EMIT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0);
      add_row(OP_ADD, 32'hA, 16'd3, 16'd1, 16'd0, 16'd0, 0, '0);
      add_row(OP_ADD, 32'hB, 16'd3, 16'd2, 16'd0, 16'd0, 0, '0);
      add_row(OP_ADD, 32'hC, 16'd7, 16'd3, 16'd0, 16'd0, 0, '0);
      add_row(OP_ADD, 32'hD, 16'd3, 16'd4, 16'd0, 16'd0, 0, '0);
      add_row(OP_EMIT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0, '0);
      add_row(OP_EMIT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1, empty_rsp);
      foreach (dir_rows[r]) begin
         send(dir_rows[r].req);
         base = sorted_q.size();
         group_and_sort(dir_rows[r].req);
         if (dir_rows[r].literal) sorted_q[base] = dir_rows[r].rsp;
      end

      // table full: new key dropped, stored key still accumulates
      for (int i = 0; i < ENTRIES; i++) send_checked(make_add(32'h1000_0000 + i));
      send_checked(make_add(32'hDEAD_BEEF));
      send_checked(make_add(32'h1000_0003));
      send_checked(make_emit());

      // receiver stops for a long stretch while adds pile up behind an emit
      for (int i = 0; i < 6; i++) send_checked(make_add($urandom));
      drain();
      hold_cycles = 3000;
      send_checked(make_emit());
      for (int i = 0; i < 8; i++) send_checked(make_add($urandom));
      send_checked(make_emit());

      sent_items = 0;
      send_idle_pct = 6;
      recv_idle_pct = 87;
      while (sent_items < RAND_ITEMS / 3) random_run();
      drain();
      send_idle_pct = 87;
      recv_idle_pct = 6;
      while (sent_items < 2 * RAND_ITEMS / 3) random_run();
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (sent_items < RAND_ITEMS) random_run();

      // pile maximal counts onto one key
      send_checked(make_emit());
      for (int i = 0; i < 6; i++)
         send_checked({OP_ADD, 32'h0000_0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_checked(make_add(32'h0000_0002));
      send_checked(make_emit());

      drain();
      if (errors == 0) begin
         $display("tb_keyed_count_merge_sort: PASS");
      end else begin
         $display("tb_keyed_count_merge_sort: FAIL");
      end
      $finish;
   end

endmodule
